// ===== sv/mpb_pkg.sv =====
`default_nettype none
package mpb_pkg;

  localparam int OP_W    = 2;
  localparam int CHAN_W  = 3;
  localparam int NOTE_W  = 7;
  localparam int DUTY_W  = 4;
  localparam int SMP_W   = 8;
  localparam int PER_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int NOTES   = 128;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE = 2'd1;
  localparam logic [OP_W-1:0] OP_DUTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SILENCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME  = 1'b1;

  localparam logic [SMP_W-1:0]  SILENCE_RST = 8'd127;
  localparam logic [SMP_W-1:0]  VOLUME_RST  = 8'd8;
  localparam logic [DUTY_W-1:0] DUTY_RST    = 4'd1;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic note_wr;
    logic duty_wr;
    logic tick_step;
    logic emit;
  } mpb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            chan_ok;
    logic            last;
    logic            out_free;
  } mpb_stat_t;

  // Step ratio numerator and denominator, step = note % 16
  function automatic int unsigned ratio_num(input int unsigned st);
    case (st)
      0: ratio_num = 0;
      1, 2, 3, 6, 8: ratio_num = 1;
      4, 5, 7, 10: ratio_num = 2;
      9: ratio_num = 3;
      11: ratio_num = 5;
      12: ratio_num = 6;
      13: ratio_num = 4;
      14: ratio_num = 7;
      default: ratio_num = 14;
    endcase
  endfunction

  function automatic int unsigned ratio_den(input int unsigned st);
    case (st)
      0: ratio_den = 1;
      1, 15: ratio_den = 15;
      2, 4, 12, 14: ratio_den = 8;
      3, 7, 9, 13: ratio_den = 5;
      5, 11: ratio_den = 7;
      6, 10: ratio_den = 3;
      default: ratio_den = 2;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== sv/mpb_in_if.sv =====
`default_nettype none
interface mpb_in_if;
  logic                          valid;
  logic                          ready;
  logic [mpb_pkg::OP_W-1:0]      operation;
  logic [mpb_pkg::CHAN_W-1:0]    channel;
  logic [mpb_pkg::NOTE_W-1:0]    note;
  logic [mpb_pkg::DUTY_W-1:0]    duty_code;

  modport source (output valid, operation, channel, note, duty_code, input ready);
  modport sink (input valid, operation, channel, note, duty_code, output ready);
endinterface
`default_nettype wire

// ===== sv/mpb_out_if.sv =====
`default_nettype none
interface mpb_out_if;
  logic                       valid;
  logic                       ready;
  logic [mpb_pkg::SMP_W-1:0]  sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface
`default_nettype wire

// ===== sv/mpb_cfg_if.sv =====
`default_nettype none
interface mpb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mpb_pkg::CFG_IDX_W-1:0]  index;
  logic [mpb_pkg::SMP_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/multichannel_pulse_beeper.sv =====
// Multichannel one-bit beeper.
// in_ch carries words {operation, channel, note, duty_code}. Operation
// tick (0) runs every active channel's square-wave counters one sample
// step and gives one word on out_ch with the 8-bit sample; set-note (1)
// looks the note up in the period table and reloads the channel counters
// when the period changed; set-duty (2) stores the duty shift. Code 3,
// and set words for a channel at or above CHANNELS, are dropped silently.
// cfg_ch writes silence_level (index 0) and volume_step (index 1); it is
// always ready and is meant to be written while no word is in flight.
// Sweep: a tick word walks the channels one per cycle through a single
// counter unit, and a new word is taken only once the tick or set word
// is done. After the sweep the sample is loaded into an output register;
// a stalled out_ch holds it and the next words are still accepted, the
// following tick waiting at its end until the register is free.
// Reset (rst_n low, synchronous) silences all channels, sets duty 1,
// clears the counters, sets the shared bit high and restores the
// configuration defaults 127 and 8.
`default_nettype none
module multichannel_pulse_beeper #(
  parameter int SAMPLE_RATE_HZ = 44100,
  parameter int CHANNELS       = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mpb_in_if.sink    in_ch,
  mpb_out_if.source out_ch,
  mpb_cfg_if.sink   cfg_ch
);

  mpb_pkg::mpb_cmd_t  cmd;
  mpb_pkg::mpb_stat_t st;
  logic               in_ready;

  assign in_ch.ready = in_ready;

  mpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  mpb_dpath #(
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
    .CHANNELS       (CHANNELS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_ch.operation),
    .in_channel   (in_ch.channel),
    .in_note      (in_ch.note),
    .in_duty_code (in_ch.duty_code),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .cmd          (cmd),
    .st           (st)
  );

endmodule
`default_nettype wire

// ===== sv/mpb_ctrl.sv =====
`default_nettype none
module mpb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output mpb_pkg::mpb_cmd_t       cmd,
  input  wire mpb_pkg::mpb_stat_t st
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SET  = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       note_r, note_nxt;
  logic       in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    note_nxt  = note_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          note_nxt    = (st.op == mpb_pkg::OP_NOTE);
          if (st.op == mpb_pkg::OP_TICK) begin
            state_nxt = S_TICK;
          end else if (st.chan_ok &&
                       (st.op == mpb_pkg::OP_NOTE || st.op == mpb_pkg::OP_DUTY)) begin
            state_nxt = S_SET;
          end
        end
      end
      S_SET: begin
        cmd.note_wr = note_r;
        cmd.duty_wr = !note_r;
        state_nxt   = S_IDLE;
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (st.last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register can take the word
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      note_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      note_r  <= note_nxt;
    end
  end

  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && st.op == mpb_pkg::OP_TICK |=> state_r == S_TICK)
    else $error("tick word did not start channel sweep");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TICK && st.last |=> state_r == S_EMIT)
    else $error("channel sweep did not end in emit");

  a_set_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SET |=> state_r == S_IDLE)
    else $error("set write took more than one cycle");

endmodule
`default_nettype wire

// ===== sv/mpb_dpath.sv =====
`default_nettype none
module mpb_dpath #(
  parameter int SAMPLE_RATE_HZ = 44100,
  parameter int CHANNELS       = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [mpb_pkg::OP_W-1:0]    in_operation,
  input  wire logic [mpb_pkg::CHAN_W-1:0]  in_channel,
  input  wire logic [mpb_pkg::NOTE_W-1:0]  in_note,
  input  wire logic [mpb_pkg::DUTY_W-1:0]  in_duty_code,
  mpb_out_if.source                        out_ch,
  mpb_cfg_if.sink                          cfg_ch,
  input  wire mpb_pkg::mpb_cmd_t           cmd,
  output mpb_pkg::mpb_stat_t               st
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PER_W = mpb_pkg::PER_W;
  localparam int DUTY_W = mpb_pkg::DUTY_W;

  // Period table, worked out at elaboration
  logic [PER_W-1:0] rom [mpb_pkg::NOTES];

  for (genvar g = 0; g < mpb_pkg::NOTES; g++) begin : g_rom
    localparam longint unsigned RP  = longint'(mpb_pkg::ratio_num(g % 16));
    localparam longint unsigned RQ  = longint'(mpb_pkg::ratio_den(g % 16));
    localparam longint unsigned NUM = longint'(SAMPLE_RATE_HZ) * RQ * 64'd10;
    localparam longint unsigned DEN = (64'd44 * (RP + RQ)) << ((g / 16) % 8);
    localparam longint unsigned PER = NUM / DEN;
    assign rom[g] = PER[PER_W-1:0];
  end

  logic [PER_W-1:0]  period_r [CHANNELS];
  logic [DUTY_W-1:0] duty_r   [CHANNELS];
  logic [PER_W-1:0]  on_r     [CHANNELS];
  logic [PER_W-1:0]  off_r    [CHANNELS];
  logic              phase_r  [CHANNELS];
  logic              level_r, level_nxt;
  logic [CH_W-1:0]   ptr_r;
  logic [CH_W-1:0]   chan_r;
  logic [mpb_pkg::NOTE_W-1:0] note_r;
  logic [DUTY_W-1:0] dcode_r;
  logic [7:0]        silence_r;
  logic [7:0]        volume_r;
  logic              out_valid_r;
  logic [7:0]        sample_r;

  logic [CH_W-1:0]   idx;
  logic [PER_W-1:0]  per_c, on_c, off_c, np;
  logic [DUTY_W-1:0] duty_c;
  logic              ph_c, active;
  logic [PER_W-1:0]  on_nxt, off_nxt;
  logic              ph_nxt, toggle;
  logic [PER_W-1:0]  rl_off_tick, rl_off_note, rl_on_note;

  function automatic logic [PER_W-1:0] reload_off(input logic [PER_W-1:0] per,
                                                  input logic [DUTY_W-1:0] dc);
    if (per == '0 || dc == '0) begin
      reload_off = '0;
    end else begin
      reload_off = per >> dc;
    end
  endfunction

  assign st.op       = in_operation;
  assign st.chan_ok  = int'(in_channel) < CHANNELS;
  assign st.last     = (ptr_r == CH_W'(CHANNELS - 1));
  assign st.out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = sample_r;
  assign cfg_ch.ready  = 1'b1;

  assign idx    = cmd.tick_step ? ptr_r : chan_r;
  assign per_c  = period_r[idx];
  assign duty_c = duty_r[idx];
  assign on_c   = on_r[idx];
  assign off_c  = off_r[idx];
  assign ph_c   = phase_r[idx];
  assign np     = rom[note_r];
  assign active = (per_c != '0) && (duty_c != '0);

  assign rl_off_tick = reload_off(per_c, duty_c);
  assign rl_off_note = reload_off(np, duty_c);
  // a muted or silent channel reloads both counters to zero
  assign rl_on_note  = (np == '0 || duty_c == '0) ? '0 : np - rl_off_note;

  // One channel of the tick sweep
  always_comb begin
    on_nxt  = on_c;
    off_nxt = off_c;
    ph_nxt  = ph_c;
    toggle  = 1'b0;
    if (active) begin
      if (!ph_c) begin
        if (on_c == '0) begin
          ph_nxt = 1'b1;
          toggle = 1'b1;
        end
        on_nxt = on_c - PER_W'(1);
      end else if (off_c == '0) begin
        ph_nxt  = 1'b0;
        toggle  = 1'b1;
        off_nxt = rl_off_tick;
        on_nxt  = per_c - rl_off_tick;
      end else begin
        off_nxt = off_c - PER_W'(1);
      end
    end
  end

  assign level_nxt = (cmd.tick_step && toggle) ? !level_r : level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        period_r[i] <= '0;
        duty_r[i]   <= mpb_pkg::DUTY_RST;
        on_r[i]     <= '0;
        off_r[i]    <= '0;
        phase_r[i]  <= 1'b0;
      end
      level_r     <= 1'b1;
      ptr_r       <= '0;
      silence_r   <= mpb_pkg::SILENCE_RST;
      volume_r    <= mpb_pkg::VOLUME_RST;
      out_valid_r <= 1'b0;
    end else begin
      level_r <= level_nxt;
      if (cmd.tick_step) begin
        on_r[idx]    <= on_nxt;
        off_r[idx]   <= off_nxt;
        phase_r[idx] <= ph_nxt;
        ptr_r        <= st.last ? '0 : ptr_r + CH_W'(1);
      end
      if (cmd.note_wr && per_c != np) begin
        period_r[idx] <= np;
        off_r[idx]    <= rl_off_note;
        on_r[idx]     <= rl_on_note;
      end
      if (cmd.duty_wr) begin
        duty_r[idx] <= dcode_r;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          mpb_pkg::REG_SILENCE: silence_r <= cfg_ch.data;
          mpb_pkg::REG_VOLUME:  volume_r  <= cfg_ch.data;
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chan_r  <= CH_W'(in_channel);
      note_r  <= in_note;
      dcode_r <= in_duty_code;
    end
    if (cmd.emit) begin
      sample_r <= level_r ? (silence_r - volume_r) : silence_r;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ch.ready))
    else $error("sample overwritten before it was taken");

  a_ptr_home: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> ptr_r == '0)
    else $error("channel pointer not at zero at word capture");

  a_level_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.tick_step |=> level_r == $past(level_r))
    else $error("output level changed outside the sweep");

endmodule
`default_nettype wire

// ===== tb/multichannel_pulse_beeper_tb.sv =====
`timescale 1ns / 100ps
module multichannel_pulse_beeper_tb;

  localparam int SAMPLE_HZ    = 44100;
  localparam int NUM_CH       = 8;
  localparam int DRAIN_CYCLES = 2 * NUM_CH + 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int CHUNKS       = 6;
  localparam int CHUNK_WORDS  = 130;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [mpb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [mpb_pkg::OP_W-1:0]   op;
    logic [mpb_pkg::CHAN_W-1:0] chan;
    logic [mpb_pkg::NOTE_W-1:0] note;
    logic [mpb_pkg::DUTY_W-1:0] duty;
  } beep_word_t;

  logic clk = 1'b0;
  logic rst_n;

  mpb_in_if  in_ch ();
  mpb_out_if out_ch ();
  mpb_cfg_if cfg_ch ();

  multichannel_pulse_beeper #(
    .SAMPLE_RATE_HZ(SAMPLE_HZ),
    .CHANNELS(NUM_CH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Step ratio p/q: period = rate * q * 10 / (44 * (p + q) * 2^oct)
  int unsigned step_num [16] = '{0, 1, 1, 1, 2, 2, 1, 2, 1, 3, 2, 5, 6, 4, 7, 14};
  int unsigned step_den [16] = '{1, 15, 8, 5, 8, 7, 3, 5, 2, 5, 3, 7, 8, 5, 8, 15};

  // Beeper state as seen from outside
  logic [mpb_pkg::SMP_W-1:0]  silence_reg;
  logic [mpb_pkg::SMP_W-1:0]  volume_reg;
  logic [mpb_pkg::PER_W-1:0]  ch_period [NUM_CH];
  logic [mpb_pkg::DUTY_W-1:0] ch_duty [NUM_CH];
  logic [mpb_pkg::PER_W-1:0]  on_left [NUM_CH];
  logic [mpb_pkg::PER_W-1:0]  off_left [NUM_CH];
  logic                       ch_high [NUM_CH];
  logic                       level;

  beep_word_t                pending_words [$];
  logic [mpb_pkg::SMP_W-1:0] expected_samples [$];
  beep_word_t                cur_word;
  int                        mismatches = 0;
  int                        cycles = 0;
  int                        src_gap = 0;
  int                        snk_gap = 0;
  bit                        no_idle = 1'b0;
  bit                        hold_go = 1'b0;
  logic                      sink_hold;

  function automatic logic [mpb_pkg::PER_W-1:0] period_of_note(
      logic [mpb_pkg::NOTE_W-1:0] n);
    longint unsigned num, den;
    int unsigned oct, st;
    oct = n >> 4;
    st  = n & 15;
    num = longint'(SAMPLE_HZ) * step_den[st] * 10;
    den = (longint'(44) * (step_num[st] + step_den[st])) << oct;
    return mpb_pkg::PER_W'(num / den);
  endfunction

  task automatic reload_counters(int c);
    if (ch_period[c] == '0 || ch_duty[c] == '0) begin
      off_left[c] = '0;
      on_left[c]  = '0;
    end else begin
      off_left[c] = ch_period[c] >> ch_duty[c];
      on_left[c]  = ch_period[c] - off_left[c];
    end
  endtask

  task automatic advance_beeper(beep_word_t w);
    logic [mpb_pkg::PER_W-1:0] np;
    if (w.op == mpb_pkg::OP_TICK) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (ch_period[c] == '0 || ch_duty[c] == '0) continue;
        if (!ch_high[c]) begin
          if (on_left[c] == '0) begin
            ch_high[c] = 1'b1;
            level = ~level;
          end
          on_left[c] = on_left[c] - 1'b1;
        end else if (off_left[c] == '0) begin
          ch_high[c] = 1'b0;
          level = ~level;
          reload_counters(c);
        end else begin
          off_left[c] = off_left[c] - 1'b1;
        end
      end
      expected_samples.push_back(level ? mpb_pkg::SMP_W'(silence_reg - volume_reg)
                                       : silence_reg);
    end else if (int'(w.chan) < NUM_CH) begin
      if (w.op == mpb_pkg::OP_NOTE) begin
        np = period_of_note(w.note);
        if (ch_period[w.chan] != np) begin
          ch_period[w.chan] = np;
          reload_counters(w.chan);
        end
      end else if (w.op == mpb_pkg::OP_DUTY) begin
        ch_duty[w.chan] = w.duty;
      end
    end
  endtask

  task automatic flag_mismatch(string what);
    $display("mismatch @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic beep_word_t mk(logic [mpb_pkg::OP_W-1:0] op, int chan, int note,
                                    int duty);
    beep_word_t w;
    w.op   = op;
    w.chan = mpb_pkg::CHAN_W'(chan);
    w.note = mpb_pkg::NOTE_W'(note);
    w.duty = mpb_pkg::DUTY_W'(duty);
    return w;
  endfunction

  // Mostly high octaves so that phases flip within a few dozen ticks
  function automatic logic [mpb_pkg::NOTE_W-1:0] pick_note();
    if ($urandom_range(0, 3) != 0)
      return {3'($urandom_range(5, 7)), 4'($urandom_range(0, 15))};
    return mpb_pkg::NOTE_W'($urandom);
  endfunction

  function automatic logic [mpb_pkg::DUTY_W-1:0] pick_duty();
    if ($urandom_range(0, 9) < 6)
      return mpb_pkg::DUTY_W'($urandom_range(1, 3));
    return mpb_pkg::DUTY_W'($urandom_range(0, 15));
  endfunction

  function automatic beep_word_t random_word();
    beep_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) w.op = mpb_pkg::OP_TICK;
    else if (r < 84) w.op = mpb_pkg::OP_NOTE;
    else if (r < 95) w.op = mpb_pkg::OP_DUTY;
    else w.op = OP_UNUSED;
    w.chan = mpb_pkg::CHAN_W'($urandom_range(0, 7));
    w.note = pick_note();
    w.duty = pick_duty();
    return w;
  endfunction

  task automatic write_reg(logic [mpb_pkg::CFG_IDX_W-1:0] idx,
                           logic [mpb_pkg::SMP_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == mpb_pkg::REG_SILENCE) silence_reg = val;
    else volume_reg = val;
  endtask

  // Look between edges so that the sender's updates have settled
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_ch.valid || expected_samples.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drive every input known before the first edge
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.channel = '0;
    in_ch.note = '0;
    in_ch.duty_code = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    sink_hold = 1'b0;
    silence_reg = mpb_pkg::SILENCE_RST;
    volume_reg = mpb_pkg::VOLUME_RST;
    level = 1'b1;
    for (int c = 0; c < NUM_CH; c++) begin
      ch_period[c] = '0;
      ch_duty[c] = mpb_pkg::DUTY_RST;
      on_left[c] = '0;
      off_left[c] = '0;
      ch_high[c] = 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[multichannel_pulse_beeper] ERROR");
      $finish;
    end
  end

  // Sender: one word offered at a time, held until taken
  always @(posedge clk) begin : drive_proc
    logic offering;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      offering = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        advance_beeper(cur_word);
        offering = 1'b0;
      end
      if (!offering) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_words.size() != 0) begin
          if (!no_idle && $urandom_range(0, 9) == 0) begin
            src_gap = $urandom_range(1, 11);
          end else begin
            cur_word = pending_words.pop_front();
            in_ch.operation <= cur_word.op;
            in_ch.channel   <= cur_word.chan;
            in_ch.note      <= cur_word.note;
            in_ch.duty_code <= cur_word.duty;
            offering = 1'b1;
          end
        end
      end
      in_ch.valid <= offering;
    end
  end

  // Receiver: check each sample against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          flag_mismatch($sformatf("sample %0d with none expected", out_ch.sample));
        end else if (out_ch.sample !== expected_samples[0]) begin
          flag_mismatch($sformatf("sample %0d, expected %0d",
                                  out_ch.sample, expected_samples[0]));
          void'(expected_samples.pop_front());
        end else begin
          void'(expected_samples.pop_front());
        end
      end
      if (snk_gap > 0) snk_gap--;
      else if (!no_idle && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 11);
      out_ch.ready <= (snk_gap == 0) && !sink_hold;
    end
  end

  // Long back-pressure: hold the output off while words keep coming
  initial begin
    wait (hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin
    logic [mpb_pkg::SMP_W-1:0] sil_set [CHUNKS];
    logic [mpb_pkg::SMP_W-1:0] vol_set [CHUNKS];
    sil_set = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd127};
    vol_set = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd8};
    sil_set[4] = mpb_pkg::SMP_W'($urandom);
    vol_set[4] = mpb_pkg::SMP_W'($urandom);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset sample, extremes, mute on reload, repeated note, unused code
    pending_words.push_back(mk(mpb_pkg::OP_TICK, 0, 0, 0));
    pending_words.push_back(mk(mpb_pkg::OP_NOTE, 0, 127, 0));
    pending_words.push_back(mk(mpb_pkg::OP_DUTY, 1, 0, 15));
    pending_words.push_back(mk(mpb_pkg::OP_NOTE, 1, 0, 0));
    pending_words.push_back(mk(mpb_pkg::OP_DUTY, 2, 0, 0));
    pending_words.push_back(mk(mpb_pkg::OP_NOTE, 2, 112, 0));
    pending_words.push_back(mk(mpb_pkg::OP_NOTE, 7, 64, 15));
    pending_words.push_back(mk(OP_UNUSED, 7, 127, 15));
    repeat (4) pending_words.push_back(mk(mpb_pkg::OP_TICK, 7, 127, 15));
    pending_words.push_back(mk(mpb_pkg::OP_NOTE, 0, 127, 0));
    pending_words.push_back(mk(mpb_pkg::OP_DUTY, 2, 0, 15));
    repeat (3) pending_words.push_back(mk(mpb_pkg::OP_TICK, 0, 0, 0));
    pending_words.push_back(mk(mpb_pkg::OP_DUTY, 0, 0, 0));
    pending_words.push_back(mk(mpb_pkg::OP_TICK, 0, 0, 0));
    pending_words.push_back(mk(mpb_pkg::OP_DUTY, 0, 0, 4));
    pending_words.push_back(mk(mpb_pkg::OP_NOTE, 0, 126, 0));
    repeat (3) pending_words.push_back(mk(mpb_pkg::OP_TICK, 0, 0, 0));
    wait_drained();

    for (int k = 0; k < CHUNKS; k++) begin
      write_reg(mpb_pkg::REG_SILENCE, sil_set[k]);
      write_reg(mpb_pkg::REG_VOLUME, vol_set[k]);
      if (k == CHUNKS - 1) no_idle = 1'b1;
      // Set up every channel, then mix ticks with random set words
      for (int c = 0; c < NUM_CH; c++) begin
        pending_words.push_back(mk(mpb_pkg::OP_DUTY, c, 0, pick_duty()));
        pending_words.push_back(mk(mpb_pkg::OP_NOTE, c, pick_note(), 0));
      end
      for (int i = 0; i < CHUNK_WORDS; i++)
        pending_words.push_back(random_word());
      if (k == 1) hold_go = 1'b1;
      wait_drained();
    end

    if (mismatches == 0)
      $display("[multichannel_pulse_beeper] OK");
    else
      $display("[multichannel_pulse_beeper] ERROR");
    $finish;
  end

endmodule
